// ===== rtl/osss_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// osss_pkg
// Types, codes and constants shared by the open element stack search core.
// ---------------------------------------------------------------------------
package osss_pkg;

   localparam int OSSS_DEPTH = 64;
   localparam int POS_W      = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_HEADING_FIRST = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CELL_DATA     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CELL_HEADER   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HTML_NS       = 2'd3;

   // heading levels one to six share consecutive codes
   localparam logic [15:0] HEADING_LEVELS = 16'd6;

   typedef enum logic [3:0] {
      KIND_PUSH          = 4'd0,
      KIND_POP           = 4'd1,
      KIND_UNTIL_TAG     = 4'd2,
      KIND_UNTIL_HEADING = 4'd3,
      KIND_UNTIL_CELL    = 4'd4,
      KIND_UNTIL_NODE    = 4'd5,
      KIND_POP_ALL       = 4'd6,
      KIND_REMOVE        = 4'd7,
      KIND_FIND_NODE     = 4'd8,
      KIND_FIND_NODE_REV = 4'd9,
      KIND_FIND_TAG      = 4'd10,
      KIND_FIND_TAG_REV  = 4'd11
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RUN_CHECK,
      ST_RUN_EVAL,
      ST_SCAN_RD,
      ST_SCAN_EVAL,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_FINISH
   } ctrl_state_type;

   typedef struct packed {
      logic [3:0]  kind;
      logic [31:0] node_handle;
      logic [15:0] tag_code;
      logic [7:0]  namespace_code;
      logic        exclude_match;
   } req_type;

   typedef struct packed {
      logic             popped;
      logic             found;
      logic [POS_W-1:0] position;
      logic [31:0]      entry_node;
      logic [15:0]      entry_tag;
      logic [7:0]       entry_namespace;
      logic             overflow;
      logic             last;
   } rsp_type;

   typedef struct packed {
      logic [31:0] node;
      logic [15:0] tag;
      logic [7:0]  ns;
   } entry_type;

   typedef struct packed {
      logic [15:0] heading_first_tag;
      logic [15:0] cell_data_tag;
      logic [15:0] cell_header_tag;
      logic [7:0]  html_namespace;
   } cfg_type;

endpackage : osss_pkg
`default_nettype wire

// ===== rtl/osss_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// osss_ram
// Generic single write, single read RAM with registered read data.
// ---------------------------------------------------------------------------
module osss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule : osss_ram
`default_nettype wire

// ===== rtl/osss_match.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// osss_match
// Shared compare unit: tests one stored entry against the current request.
// ---------------------------------------------------------------------------
module osss_match
   import osss_pkg::*;
(
   input  wire entry_type entry,
   input  wire req_type   op,
   input  wire cfg_type   cfg,
   output logic           hit
);

   logic        tag_eq;
   logic        node_eq;
   logic        html_ns;
   logic [15:0] head_off;
   logic        head_hit;

   always_comb begin
      tag_eq   = (entry.tag == op.tag_code) && (entry.ns == op.namespace_code);
      node_eq  = (entry.node == op.node_handle);
      html_ns  = (entry.ns == cfg.html_namespace);
      head_off = entry.tag - cfg.heading_first_tag;
      head_hit = html_ns && (entry.tag >= cfg.heading_first_tag)
                 && (head_off < HEADING_LEVELS);
   end

   always_comb begin
      case (kind_type'(op.kind))
         KIND_UNTIL_TAG, KIND_FIND_TAG, KIND_FIND_TAG_REV: begin
            hit = tag_eq;
         end
         KIND_UNTIL_HEADING: begin
            hit = head_hit;
         end
         KIND_UNTIL_CELL: begin
            hit = html_ns && ((entry.tag == cfg.cell_data_tag)
                              || (entry.tag == cfg.cell_header_tag));
         end
         KIND_UNTIL_NODE, KIND_REMOVE, KIND_FIND_NODE, KIND_FIND_NODE_REV: begin
            hit = node_eq;
         end
         default: begin
            hit = 1'b0;
         end
      endcase
   end

endmodule : osss_match
`default_nettype wire

// ===== rtl/osss_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// osss_ctrl
// Sequencer: stack count, scan pointer, pending result and output register.
// ---------------------------------------------------------------------------
module osss_ctrl
   import osss_pkg::*;
#(
   parameter int DEPTH = OSSS_DEPTH
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire req_type                  req_data,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output rsp_type                       rsp_data,
   output req_type                       op,
   input  wire logic                     hit,
   output logic                          wr_en,
   output logic      [$clog2(DEPTH)-1:0] wr_addr,
   output entry_type                     wr_data,
   output logic      [$clog2(DEPTH)-1:0] rd_addr,
   input  wire entry_type                rd_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] FULL = CW'(DEPTH);
   localparam logic [CW-1:0] ONE  = CW'(1);

   ctrl_state_type state_ff, state_in;
   req_type        op_ff, op_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [CW-1:0]  ptr_ff, ptr_in;
   rsp_type        pend_ff, pend_in;
   logic           pend_valid_ff, pend_valid_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_data_ff, rsp_data_in;

   kind_type      req_kind;
   kind_type      op_kind;
   logic          accept;
   logic          out_free;
   logic          forward;
   logic          excl_eff;
   logic          stop_keep;
   logic          run_stall;
   logic          scan_end;
   logic [CW-1:0] cnt_m1;
   logic [CW-1:0] ptr_p1;
   logic [CW-1:0] ptr_m1;
   logic [CW-1:0] ptr_next;

   always_comb begin
      req_kind  = kind_type'(req_data.kind);
      op_kind   = kind_type'(op_ff.kind);
      req_ready = (state_ff == ST_IDLE);
      accept    = req_valid && req_ready;
      out_free  = !rsp_valid_ff || rsp_ready;
      forward   = op_kind inside {KIND_FIND_NODE, KIND_FIND_TAG};
      excl_eff  = (op_kind inside {KIND_UNTIL_TAG, KIND_UNTIL_NODE}) ?
                  op_ff.exclude_match : 1'b1;
      stop_keep = hit && !excl_eff;
      run_stall = pend_valid_ff && !out_free;
      cnt_m1    = count_ff - ONE;
      ptr_p1    = ptr_ff + ONE;
      ptr_m1    = ptr_ff - ONE;
      ptr_next  = forward ? ptr_p1 : ptr_m1;
      scan_end  = forward ? (ptr_ff == cnt_m1) : (ptr_ff == '0);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_kind)
                  KIND_POP, KIND_UNTIL_TAG, KIND_UNTIL_HEADING, KIND_UNTIL_CELL,
                  KIND_UNTIL_NODE, KIND_POP_ALL: begin
                     state_in = ST_RUN_CHECK;
                  end
                  KIND_REMOVE, KIND_FIND_NODE, KIND_FIND_NODE_REV, KIND_FIND_TAG,
                  KIND_FIND_TAG_REV: begin
                     state_in = (count_ff == '0) ? ST_FINISH : ST_SCAN_RD;
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_RUN_CHECK: begin
            state_in = (count_ff == '0) ? ST_FINISH : ST_RUN_EVAL;
         end
         ST_RUN_EVAL: begin
            if (stop_keep) begin
               state_in = ST_FINISH;
            end else if (!run_stall) begin
               state_in = (hit || op_kind == KIND_POP) ? ST_FINISH : ST_RUN_CHECK;
            end
         end
         ST_SCAN_RD: begin
            state_in = ST_SCAN_EVAL;
         end
         ST_SCAN_EVAL: begin
            if (hit) begin
               state_in = (op_kind == KIND_REMOVE) ? ST_SHIFT_RD : ST_FINISH;
            end else if (scan_end) begin
               state_in = ST_FINISH;
            end
         end
         ST_SHIFT_RD: begin
            state_in = (ptr_p1 == count_ff) ? ST_FINISH : ST_SHIFT_WR;
         end
         ST_SHIFT_WR: begin
            state_in = ST_SHIFT_RD;
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      op_in         = op_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      wr_en         = 1'b0;
      wr_addr       = count_ff[AW-1:0];
      wr_data       = rd_data;
      rd_addr       = ptr_ff[AW-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in         = req_data;
               pend_in       = '0;
               pend_valid_in = 1'b0;
               ptr_in        = (req_kind inside {KIND_FIND_NODE, KIND_FIND_TAG}) ?
                               '0 : cnt_m1;
               if (req_kind == KIND_PUSH) begin
                  if (count_ff == FULL) begin
                     pend_in.overflow = 1'b1;
                  end else begin
                     wr_en         = 1'b1;
                     wr_data.node  = req_data.node_handle;
                     wr_data.tag   = req_data.tag_code;
                     wr_data.ns    = req_data.namespace_code;
                     count_in      = count_ff + ONE;
                  end
               end
            end
         end
         ST_RUN_CHECK, ST_RUN_EVAL: begin
            rd_addr = cnt_m1[AW-1:0];
            if (state_ff == ST_RUN_EVAL && !stop_keep && !run_stall) begin
               if (pend_valid_ff) begin
                  rsp_valid_in     = 1'b1;
                  rsp_data_in      = pend_ff;
                  rsp_data_in.last = 1'b0;
               end
               pend_in.popped          = 1'b1;
               pend_in.found           = hit;
               pend_in.position        = POS_W'(cnt_m1[AW-1:0]);
               pend_in.entry_node      = rd_data.node;
               pend_in.entry_tag       = rd_data.tag;
               pend_in.entry_namespace = rd_data.ns;
               pend_in.overflow        = 1'b0;
               pend_in.last            = 1'b0;
               pend_valid_in           = 1'b1;
               count_in                = cnt_m1;
            end
         end
         ST_SCAN_RD: begin
            rd_addr = ptr_ff[AW-1:0];
         end
         ST_SCAN_EVAL: begin
            rd_addr = ptr_next[AW-1:0];
            if (hit) begin
               pend_in.popped          = (op_kind == KIND_REMOVE);
               pend_in.found           = 1'b1;
               pend_in.position        = POS_W'(ptr_ff[AW-1:0]);
               pend_in.entry_node      = rd_data.node;
               pend_in.entry_tag       = rd_data.tag;
               pend_in.entry_namespace = rd_data.ns;
               pend_in.overflow        = 1'b0;
               pend_in.last            = 1'b0;
               pend_valid_in           = 1'b1;
            end else begin
               ptr_in = ptr_next;
            end
         end
         ST_SHIFT_RD: begin
            rd_addr = ptr_p1[AW-1:0];
            if (ptr_p1 == count_ff) begin
               count_in = cnt_m1;
            end
         end
         ST_SHIFT_WR: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff[AW-1:0];
            wr_data = rd_data;
            ptr_in  = ptr_p1;
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_data_in      = pend_ff;
               rsp_data_in.last = 1'b1;
               pend_valid_in    = 1'b0;
            end
         end
         default: begin
            pend_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      op_ff       <= op_in;
      ptr_ff      <= ptr_in;
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign op        = op_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL)
      else $error("stack count above depth");

   a_push_grows : assert property (@(posedge clock) disable iff (reset)
      (accept && req_kind == KIND_PUSH && count_ff != FULL)
      |=> (count_ff == $past(count_ff) + ONE))
      else $error("push did not grow the stack");

   a_idle_no_pend : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_valid_ff)
      else $error("pending result left over in idle");

   a_pend_content : assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> (pend_ff.popped || pend_ff.found))
      else $error("pending result carries no entry");

   a_mid_is_pop : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.last) |-> rsp_data_ff.popped)
      else $error("non-final result without a popped entry");

endmodule : osss_ctrl
`default_nettype wire

// ===== rtl/open_element_stack_search_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// open_element_stack_search_core
// Searchable stack of open elements with pop runs, removal and searches.
//
// req_* takes one stack operation per request (valid/ready); req_ready is
// low while an operation is in progress. rsp_* returns one or more results
// per request, the final one flagged by last; popped entries come top first.
// csr_* writes the heading, cell and namespace codes, one register per cycle.
// Steps per request, from acceptance to the final result being loaded:
//   push, unused kinds, search or remove on an empty stack: finish only
//   pop runs: check and evaluate states per entry, a final check on empty
//   searches, remove without a match: a read, then an evaluate per entry
//   remove with a match: the scan, then a read and a write per entry shifted
// A new request is accepted in the cycle after the final result is loaded.
// The registered read of the entry RAM is why each pop needs a check state.
// A stalled rsp_ready holds the output register and the sequencer waits on
// it before loading the next result; nothing is dropped.
// Reset empties the stack and clears the configuration registers; no
// clearing pass runs, stale RAM contents are never read.
// ---------------------------------------------------------------------------
module open_element_stack_search_core
   import osss_pkg::*;
#(
   parameter int DEPTH = OSSS_DEPTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int AW = $clog2(DEPTH);

   cfg_type   cfg_ff, cfg_in;
   req_type   op;
   logic      hit;
   logic      wr_en;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;
   entry_type wr_data;
   entry_type rd_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_HEADING_FIRST: cfg_in.heading_first_tag = csr_wdata;
            CSR_CELL_DATA:     cfg_in.cell_data_tag     = csr_wdata;
            CSR_CELL_HEADER:   cfg_in.cell_header_tag   = csr_wdata;
            CSR_HTML_NS:       cfg_in.html_namespace    = csr_wdata[7:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   osss_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .op        (op),
      .hit       (hit),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   osss_match u_match (
      .entry (rd_data),
      .op    (op),
      .cfg   (cfg_ff),
      .hit   (hit)
   );

   osss_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule : open_element_stack_search_core
`default_nettype wire

// ===== sim/open_element_stack_search_core_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// open_element_stack_search_core_tb
// Self-checking bench for the searchable open element stack. A mirror of the
// stack and its configuration predicts every result of each accepted request,
// and each returned result is compared field by field in order. Directed
// requests cover empty stack cases, every operation and the edges of the
// heading and cell matches. Random requests follow, drawn mostly from small
// pools of nodes, tags and namespaces so that searches and pop runs hit
// stored entries. The stack is also filled to overflow. Both handshakes
// idle at random in all but the last phase, each with its own configuration.
// ---------------------------------------------------------------------------
module open_element_stack_search_core_tb
   import osss_pkg::*;
();

   class element_stack_mirror;
      entry_type   slots [OSSS_DEPTH];
      int unsigned depth_used;
      cfg_type     regs;
      rsp_type     pending_results [$];
      rsp_type     batch [$];
      int unsigned mismatch_count;
      int unsigned result_count;

      function new();
         depth_used     = 0;
         regs           = '0;
         mismatch_count = 0;
         result_count   = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
         case (index)
            CSR_HEADING_FIRST: regs.heading_first_tag = value;
            CSR_CELL_DATA:     regs.cell_data_tag     = value;
            CSR_CELL_HEADER:   regs.cell_header_tag   = value;
            CSR_HTML_NS:       regs.html_namespace    = value[7:0];
            default: ;
         endcase
      endfunction

      function void add_result(logic popped, logic found, int unsigned pos, entry_type e,
                               logic ovf);
         rsp_type r;
         r                 = '0;
         r.popped          = popped;
         r.found           = found;
         r.position        = pos[POS_W-1:0];
         r.entry_node      = e.node;
         r.entry_tag       = e.tag;
         r.entry_namespace = e.ns;
         r.overflow        = ovf;
         batch.push_back(r);
      endfunction

      function bit run_stops(entry_type e, req_type op);
         case (op.kind)
            KIND_UNTIL_TAG:
               return e.tag == op.tag_code && e.ns == op.namespace_code;
            KIND_UNTIL_HEADING:
               return e.ns == regs.html_namespace && e.tag >= regs.heading_first_tag
                      && (e.tag - regs.heading_first_tag) < HEADING_LEVELS;
            KIND_UNTIL_CELL:
               return e.ns == regs.html_namespace
                      && (e.tag == regs.cell_data_tag || e.tag == regs.cell_header_tag);
            KIND_UNTIL_NODE:
               return e.node == op.node_handle;
            default:
               return 1'b0;
         endcase
      endfunction

      function bit search_hits(entry_type e, req_type op);
         if (op.kind == KIND_FIND_NODE || op.kind == KIND_FIND_NODE_REV)
            return e.node == op.node_handle;
         return e.tag == op.tag_code && e.ns == op.namespace_code;
      endfunction

      function void pop_run(req_type op, bit take_match);
         entry_type e;
         bit        hit;
         while (depth_used != 0) begin
            e   = slots[depth_used - 1];
            hit = run_stops(e, op);
            if (hit && !take_match)
               break;
            depth_used--;
            add_result(1'b1, hit, depth_used, e, 1'b0);
            if (hit)
               break;
         end
      endfunction

      function void accept_op(req_type op);
         entry_type blank;
         entry_type e;
         rsp_type   tail;
         int        i;
         int        j;
         blank = '0;
         batch.delete();
         case (op.kind)
            KIND_PUSH: begin
               if (depth_used >= OSSS_DEPTH) begin
                  add_result(1'b0, 1'b0, 0, blank, 1'b1);
               end else begin
                  e.node = op.node_handle;
                  e.tag  = op.tag_code;
                  e.ns   = op.namespace_code;
                  slots[depth_used] = e;
                  depth_used++;
               end
            end
            KIND_POP: begin
               if (depth_used != 0) begin
                  depth_used--;
                  add_result(1'b1, 1'b0, depth_used, slots[depth_used], 1'b0);
               end
            end
            KIND_UNTIL_TAG, KIND_UNTIL_NODE:
               pop_run(op, op.exclude_match);
            KIND_UNTIL_HEADING, KIND_UNTIL_CELL, KIND_POP_ALL:
               pop_run(op, 1'b1);
            KIND_REMOVE: begin
               for (i = int'(depth_used) - 1; i >= 0; i--) begin
                  if (slots[i].node == op.node_handle) begin
                     e = slots[i];
                     for (j = i; j < int'(depth_used) - 1; j++)
                        slots[j] = slots[j + 1];
                     depth_used--;
                     add_result(1'b1, 1'b1, i, e, 1'b0);
                     break;
                  end
               end
            end
            KIND_FIND_NODE, KIND_FIND_TAG: begin
               for (i = 0; i < int'(depth_used); i++) begin
                  if (search_hits(slots[i], op)) begin
                     add_result(1'b0, 1'b1, i, slots[i], 1'b0);
                     break;
                  end
               end
            end
            KIND_FIND_NODE_REV, KIND_FIND_TAG_REV: begin
               for (i = int'(depth_used) - 1; i >= 0; i--) begin
                  if (search_hits(slots[i], op)) begin
                     add_result(1'b0, 1'b1, i, slots[i], 1'b0);
                     break;
                  end
               end
            end
            default: ;
         endcase
         if (batch.size() == 0)
            add_result(1'b0, 1'b0, 0, blank, 1'b0);
         tail      = batch.pop_back();
         tail.last = 1'b1;
         batch.push_back(tail);
         foreach (batch[k])
            pending_results.push_back(batch[k]);
      endfunction

      task flag_mismatch(string msg);
         mismatch_count++;
         $display("mismatch at result %0d: %s", result_count, msg);
      endtask

      task compare_field(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want)
            flag_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
      endtask

      task compare_result(rsp_type got);
         rsp_type want;
         result_count++;
         if (pending_results.size() == 0) begin
            flag_mismatch("result with no request outstanding");
            return;
         end
         want = pending_results.pop_front();
         compare_field("popped", got.popped, want.popped);
         compare_field("found", got.found, want.found);
         compare_field("position", got.position, want.position);
         compare_field("entry_node", got.entry_node, want.entry_node);
         compare_field("entry_tag", got.entry_tag, want.entry_tag);
         compare_field("entry_namespace", got.entry_namespace, want.entry_namespace);
         compare_field("overflow", got.overflow, want.overflow);
         compare_field("last", got.last, want.last);
      endtask
   endclass

   localparam logic [3:0] FIRST_UNUSED_KIND = 4'd12;
   localparam logic [3:0] LAST_UNUSED_KIND  = 4'd15;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   element_stack_mirror mirror;
   int unsigned         send_idle_pct = 0;
   int unsigned         take_idle_pct = 0;
   logic [31:0]         node_pool [8];
   logic [15:0]         tag_pool [8];
   logic [7:0]          ns_pool [4];

   open_element_stack_search_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= take_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         mirror.compare_result(rsp_data);
   end

   task issue(input logic [3:0] kind, input logic [31:0] node, input logic [15:0] tag,
              input logic [7:0] ns, input logic excl);
      req_type op;
      op.kind           = kind;
      op.node_handle    = node;
      op.tag_code       = tag;
      op.namespace_code = ns;
      op.exclude_match  = excl;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= op;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      mirror.accept_op(op);
      @(negedge clock);
   endtask

   // hold off requests until every result is back
   task drain();
      req_valid <= 1'b0;
      do
         @(negedge clock);
      while (mirror.pending_results.size() != 0);
   endtask

   task write_csr(input logic [CSR_IDX_W-1:0] index, input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      mirror.write_reg(index, value);
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task set_config(input logic [15:0] heading_first, input logic [15:0] cell_data,
                   input logic [15:0] cell_header, input logic [15:0] html_ns);
      drain();
      repeat (8) @(negedge clock);
      write_csr(CSR_HEADING_FIRST, heading_first);
      write_csr(CSR_CELL_DATA, cell_data);
      write_csr(CSR_CELL_HEADER, cell_header);
      write_csr(CSR_HTML_NS, html_ns);
      node_pool[0] = 32'h0000_0000;
      node_pool[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < 8; i++)
         node_pool[i] = $urandom;
      tag_pool[0] = mirror.regs.heading_first_tag;
      tag_pool[1] = mirror.regs.heading_first_tag + 16'd2;
      tag_pool[2] = mirror.regs.heading_first_tag + 16'd5;
      tag_pool[3] = mirror.regs.heading_first_tag + 16'd6;
      tag_pool[4] = mirror.regs.cell_data_tag;
      tag_pool[5] = mirror.regs.cell_header_tag;
      tag_pool[6] = 16'hFFFF;
      tag_pool[7] = 16'($urandom);
      ns_pool[0] = mirror.regs.html_namespace;
      ns_pool[1] = mirror.regs.html_namespace + 8'd1;
      ns_pool[2] = 8'h00;
      ns_pool[3] = 8'hFF;
   endtask

   function logic [31:0] pick_node();
      return ($urandom_range(9) < 8) ? node_pool[$urandom_range(7)] : 32'($urandom);
   endfunction

   function logic [15:0] pick_tag();
      return ($urandom_range(9) < 8) ? tag_pool[$urandom_range(7)] : 16'($urandom);
   endfunction

   function logic [7:0] pick_ns();
      return ($urandom_range(3) != 0) ? ns_pool[$urandom_range(3)] : 8'($urandom);
   endfunction

   task random_op();
      int unsigned roll;
      logic [3:0]  kind;
      roll = $urandom_range(99);
      if (roll < 40)      kind = KIND_PUSH;
      else if (roll < 47) kind = KIND_POP;
      else if (roll < 54) kind = KIND_UNTIL_TAG;
      else if (roll < 59) kind = KIND_UNTIL_HEADING;
      else if (roll < 64) kind = KIND_UNTIL_CELL;
      else if (roll < 70) kind = KIND_UNTIL_NODE;
      else if (roll < 73) kind = KIND_POP_ALL;
      else if (roll < 79) kind = KIND_REMOVE;
      else if (roll < 84) kind = KIND_FIND_NODE;
      else if (roll < 89) kind = KIND_FIND_NODE_REV;
      else if (roll < 93) kind = KIND_FIND_TAG;
      else if (roll < 97) kind = KIND_FIND_TAG_REV;
      else                kind = 4'($urandom_range(LAST_UNUSED_KIND, FIRST_UNUSED_KIND));
      issue(kind, pick_node(), pick_tag(), pick_ns(), 1'($urandom_range(1)));
   endtask

   task random_phase(input int unsigned count);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(39) == 0)
            drain();
         random_op();
      end
   endtask

   // push to full, then two pushes that overflow
   task fill_stack();
      while (mirror.depth_used < OSSS_DEPTH)
         issue(KIND_PUSH, pick_node(), pick_tag(), pick_ns(), 1'($urandom_range(1)));
      repeat (2) issue(KIND_PUSH, pick_node(), pick_tag(), pick_ns(), 1'b1);
   endtask

   task directed_ops();
      // empty stack
      issue(KIND_POP, 32'h0, 16'h0, 8'h00, 1'b0);
      issue(KIND_UNTIL_TAG, 32'h0, 16'h0010, 8'h01, 1'b1);
      issue(KIND_REMOVE, 32'hFFFF_FFFF, 16'h0, 8'h00, 1'b0);
      issue(KIND_FIND_TAG_REV, 32'h0, 16'hFFFF, 8'hFF, 1'b0);
      issue(KIND_PUSH, 32'h0000_0000, 16'h0010, 8'h01, 1'b0);
      issue(KIND_PUSH, 32'hFFFF_FFFF, 16'h0021, 8'h01, 1'b0);
      issue(KIND_PUSH, 32'h0000_0005, 16'hFFFF, 8'hFF, 1'b1);
      issue(KIND_PUSH, 32'h0000_0005, 16'h0015, 8'h01, 1'b0);
      issue(KIND_PUSH, 32'h0000_0007, 16'h0016, 8'h01, 1'b0);
      issue(KIND_FIND_NODE, 32'h5, 16'h0, 8'h00, 1'b0);
      issue(KIND_FIND_NODE_REV, 32'h5, 16'h0, 8'h00, 1'b0);
      issue(KIND_FIND_TAG, 32'h0, 16'hFFFF, 8'hFF, 1'b0);
      issue(KIND_FIND_TAG_REV, 32'h0, 16'h0010, 8'h01, 1'b0);
      issue(KIND_FIND_NODE, 32'h9, 16'h0, 8'h00, 1'b0);
      // level six heading just below a non-heading tag
      issue(KIND_UNTIL_HEADING, 32'h0, 16'h0, 8'h00, 1'b0);
      // match on top without exclude pops nothing
      issue(KIND_UNTIL_TAG, 32'h0, 16'hFFFF, 8'hFF, 1'b0);
      issue(KIND_UNTIL_NODE, 32'hFFFF_FFFF, 16'h0, 8'h00, 1'b1);
      issue(KIND_PUSH, 32'h0000_0003, 16'h0020, 8'h01, 1'b0);
      issue(KIND_PUSH, 32'h0000_0004, 16'h0030, 8'h02, 1'b0);
      issue(KIND_PUSH, 32'h0000_0006, 16'h0040, 8'h02, 1'b0);
      // removal from the middle shifts the top entry down
      issue(KIND_REMOVE, 32'h4, 16'h0, 8'h00, 1'b0);
      issue(KIND_UNTIL_CELL, 32'h0, 16'h0, 8'h00, 1'b0);
      issue(KIND_UNTIL_NODE, 32'h0, 16'h0, 8'h00, 1'b0);
      issue(KIND_POP, 32'h0, 16'h0, 8'h00, 1'b0);
      issue(LAST_UNUSED_KIND, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 1'b1);
      issue(KIND_PUSH, 32'h0000_0001, 16'h0011, 8'h01, 1'b0);
      issue(KIND_POP_ALL, 32'h0, 16'h0, 8'h00, 1'b0);
   endtask

   initial begin
      mirror = new();
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct = 26;
      take_idle_pct = 87;
      set_config(16'h0010, 16'h0020, 16'h0021, 16'h0001);
      directed_ops();
      set_config(16'hFFFA, 16'h0000, 16'hFFFF, 16'h00FF);
      fill_stack();
      random_phase(35);

      send_idle_pct = 87;
      take_idle_pct = 26;
      set_config(16'h0000, 16'($urandom), 16'($urandom), 16'h0000);
      random_phase(35);

      send_idle_pct = 0;
      take_idle_pct = 0;
      set_config(16'hFFFF, 16'($urandom), 16'($urandom), 16'($urandom));
      random_phase(40);

      drain();
      repeat (20) @(negedge clock);
      if (mirror.mismatch_count == 0 && mirror.pending_results.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("status: fail");
      $finish;
   end

endmodule

// ===== open_element_stack_search_core.f =====
rtl/osss_pkg.sv
rtl/osss_ram.sv
rtl/osss_match.sv
rtl/osss_ctrl.sv
rtl/open_element_stack_search_core.sv
sim/open_element_stack_search_core_tb.sv
